/* hdl/rrnt_pkg.sv */
// Shared types and constants for the RSSI-ranked neighbor table.
// No dependencies. Used by rrnt_cell, rrnt_xchg and rssi_ranked_neighbor_table.
package rrnt_pkg;

    localparam int ID_W   = 8;
    localparam int RSSI_W = 16;
    localparam int LIFE_W = 4;
    localparam int CNT_W  = 3;

    localparam logic [LIFE_W-1:0] LIFE_RESET = 4'd5;

    // One table entry. An empty entry is all zeros.
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [RSSI_W-1:0] rssi;
        logic [LIFE_W-1:0]        life;
    } slot_t;

    // Controls broadcast to every cell of the ring.
    typedef struct packed {
        logic shift;
        logic tick;
    } cell_ctrl_t;

    // Controls of the compare-exchange unit.
    typedef struct packed {
        logic en;
        logic wr_en;
    } xchg_ctrl_t;

    typedef enum logic [2:0] {
        OUT_UPDATED  = 3'd0,
        OUT_INSERTED = 3'd1,
        OUT_REPLACED = 3'd2,
        OUT_DROPPED  = 3'd3,
        OUT_AGED     = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_DONE
    } state_t;

endpackage

/* hdl/rrnt_cell.sv */
// One table cell: holds a single entry, shifts it down the ring and ages it.
// Depends on rrnt_pkg.
module rrnt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  rrnt_pkg::cell_ctrl_t ctrl,
    input  rrnt_pkg::slot_t     shift_in,
    output rrnt_pkg::slot_t     slot,
    output logic                evicting
);

    rrnt_pkg::slot_t               slot_reg;
    rrnt_pkg::slot_t               slot_next;
    logic [rrnt_pkg::LIFE_W-1:0]   life_dec;

    always_comb
    begin
        life_dec = (slot_reg.life != '0) ? slot_reg.life - 1'b1 : '0;
    end

    // A live entry is cleared when this tick brings its lifetime to zero.
    assign evicting = (life_dec == '0) && (slot_reg.id != '0);

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.shift)
        begin
            slot_next = shift_in;
        end
        else if (ctrl.tick)
        begin
            if (life_dec == '0)
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next.life = life_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

/* hdl/rrnt_xchg.sv */
// Compare-exchange unit at the head of the cell ring; carries the running maximum.
// Depends on rrnt_pkg.
module rrnt_xchg
#(
    parameter int TABLE_DEPTH = 5
)
(
    input  logic                           clk,
    input  rrnt_pkg::xchg_ctrl_t           ctrl,
    input  logic [$clog2(TABLE_DEPTH)-1:0] pass_idx,
    input  logic [$clog2(TABLE_DEPTH)-1:0] step_idx,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_idx,
    input  rrnt_pkg::slot_t                new_slot,
    input  rrnt_pkg::slot_t                elem,
    output rrnt_pkg::slot_t                ret
);

    localparam int PW = $clog2(TABLE_DEPTH);

    rrnt_pkg::slot_t hold_reg;
    rrnt_pkg::slot_t hold_next;
    rrnt_pkg::slot_t elem_eff;

    // The new entry replaces its target slot as that slot passes in the first pass.
    assign elem_eff = (ctrl.wr_en && (step_idx == wr_idx)) ? new_slot : elem;

    always_comb
    begin
        hold_next = hold_reg;
        ret       = elem_eff;
        if (step_idx == pass_idx)
        begin
            hold_next = elem_eff;
        end
        else if (step_idx > pass_idx)
        begin
            if ($signed(hold_reg.rssi) < $signed(elem_eff.rssi))
            begin
                ret       = hold_reg;
                hold_next = elem_eff;
            end
        end
        else if ((pass_idx != '0) && (step_idx == pass_idx - PW'(1)))
        begin
            // The winner of the previous pass lands in its final slot.
            ret = hold_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            hold_reg <= hold_next;
        end
    end

endmodule

/* hdl/rssi_ranked_neighbor_table.sv */
// Top level of the RSSI-ranked neighbor table: cell ring, exchange unit and sequencer.
// Depends on rrnt_pkg, rrnt_cell and rrnt_xchg.
//
//  Channel  | Direction | Signals                      | Contents
//  ---------+-----------+------------------------------+-------------------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata    | request: tuser = req_type,
//           |           | s_tuser                      | tdata = neighbor_id, rssi
//  m_*      | out       | m_tvalid m_tready m_tdata    | result: tuser = outcome, tdata = best
//           |           | m_tuser                      | id, best rssi, live and evicted counts
//  cfg_*    | in        | cfg_wr_en cfg_wr_data        | lifetime reload value
//
// A tick or a dropped packet goes from idle straight to the final state, which loads the
// result into the output register once that register is free and then returns to idle. A
// packet that changes the table passes through the sort state first: the ring of cells
// rotates once per sorting pass through the single compare-exchange unit, and there are
// TABLE_DEPTH passes. A new request is taken while the previous result still waits in the
// output register; a stalled output only holds the block in its final state. Reset empties
// every slot and sets the lifetime reload to five; no clearing pass is needed.
module rssi_ranked_neighbor_table
#(
    parameter int TABLE_DEPTH = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] neighbor_id, [23:8] rssi
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] best_id, [23:8] best_rssi, [26:24] live_count,
                                   // [29:27] evicted_count, [31:30] zero
    output logic [2:0]  m_tuser,   // [2:0] outcome
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data
);

    localparam int PW   = $clog2(TABLE_DEPTH);
    localparam int POPW = ($clog2(TABLE_DEPTH + 1) > rrnt_pkg::CNT_W) ?
                          $clog2(TABLE_DEPTH + 1) : rrnt_pkg::CNT_W;
    localparam logic [PW-1:0] LAST_IDX = PW'(TABLE_DEPTH - 1);

    rrnt_pkg::state_t     state_reg;
    rrnt_pkg::state_t     state_next;
    rrnt_pkg::slot_t      slots [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] evict_vec;
    rrnt_pkg::slot_t      ret_slot;
    rrnt_pkg::cell_ctrl_t cell_ctrl;
    rrnt_pkg::xchg_ctrl_t xchg_ctrl;

    logic [PW-1:0]              pass_reg;
    logic [PW-1:0]              pass_next;
    logic [PW-1:0]              step_reg;
    logic [PW-1:0]              step_next;
    logic                       write_reg;
    logic                       write_next;
    logic [PW-1:0]              widx_reg;
    logic [PW-1:0]              widx_next;
    rrnt_pkg::slot_t            new_reg;
    rrnt_pkg::slot_t            new_next;
    rrnt_pkg::outcome_t         outcome_reg;
    rrnt_pkg::outcome_t         outcome_next;
    logic [rrnt_pkg::CNT_W-1:0] evicted_reg;
    logic [rrnt_pkg::CNT_W-1:0] evicted_next;
    logic [rrnt_pkg::LIFE_W-1:0] lifetime_reg;
    logic [rrnt_pkg::LIFE_W-1:0] lifetime_next;
    logic                       m_tvalid_reg;
    logic                       m_tvalid_next;
    logic [31:0]                m_tdata_reg;
    logic [31:0]                m_tdata_next;
    logic [2:0]                 m_tuser_reg;
    logic [2:0]                 m_tuser_next;

    logic                       in_acc;
    logic                       is_tick;
    logic                       sort_last;
    logic                       out_load;
    logic [rrnt_pkg::ID_W-1:0]  in_id;
    logic signed [rrnt_pkg::RSSI_W-1:0] in_rssi;

    logic                       match_hit;
    logic [PW-1:0]              match_idx;
    logic                       empty_hit;
    logic [PW-1:0]              empty_idx;
    rrnt_pkg::outcome_t         rx_outcome;
    logic                       rx_write;
    logic [PW-1:0]              rx_idx;
    logic [POPW-1:0]            live_cnt;
    logic [POPW-1:0]            evict_cnt;

    // The ring shifts toward slot zero; the element leaving slot zero passes through the
    // exchange unit and re-enters at the far end, so one rotation presents the slots in
    // index order and leaves the ring aligned again.
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        rrnt_pkg::slot_t shift_in;
        if (k == TABLE_DEPTH - 1)
        begin : g_tail
            assign shift_in = ret_slot;
        end
        else
        begin : g_body
            assign shift_in = slots[k+1];
        end

        rrnt_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .shift_in (shift_in),
            .slot     (slots[k]),
            .evicting (evict_vec[k])
        );
    end

    rrnt_xchg #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_xchg (
        .clk      (clk),
        .ctrl     (xchg_ctrl),
        .pass_idx (pass_reg),
        .step_idx (step_reg),
        .wr_idx   (widx_reg),
        .new_slot (new_reg),
        .elem     (slots[0]),
        .ret      (ret_slot)
    );

    assign in_id   = s_tdata[7:0];
    assign in_rssi = $signed(s_tdata[23:8]);
    assign is_tick = s_tuser[0];
    assign in_acc  = s_tvalid && s_tready;

    // Lookup against the aligned ring: first matching id, then first empty slot.
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        empty_hit = 1'b0;
        empty_idx = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (!match_hit && (slots[k].id == in_id))
            begin
                match_hit = 1'b1;
                match_idx = PW'(k);
            end
            if (!empty_hit && (slots[k].id == '0))
            begin
                empty_hit = 1'b1;
                empty_idx = PW'(k);
            end
        end
    end

    always_comb
    begin
        rx_outcome = rrnt_pkg::OUT_DROPPED;
        rx_write   = 1'b0;
        rx_idx     = '0;
        if (in_id == '0)
        begin
            // A zero id never enters the table.
            rx_outcome = rrnt_pkg::OUT_DROPPED;
        end
        else if (match_hit)
        begin
            rx_outcome = rrnt_pkg::OUT_UPDATED;
            rx_write   = 1'b1;
            rx_idx     = match_idx;
        end
        else if (empty_hit)
        begin
            rx_outcome = rrnt_pkg::OUT_INSERTED;
            rx_write   = 1'b1;
            rx_idx     = empty_idx;
        end
        else if (in_rssi > $signed(slots[TABLE_DEPTH-1].rssi))
        begin
            rx_outcome = rrnt_pkg::OUT_REPLACED;
            rx_write   = 1'b1;
            rx_idx     = LAST_IDX;
        end
    end

    always_comb
    begin
        live_cnt  = '0;
        evict_cnt = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            live_cnt  = live_cnt + POPW'(slots[k].id != '0);
            evict_cnt = evict_cnt + POPW'(evict_vec[k]);
        end
    end

    assign sort_last = (step_reg == LAST_IDX) && (pass_reg == LAST_IDX);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrnt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (!is_tick && rx_write) ? rrnt_pkg::ST_SORT
                                                        : rrnt_pkg::ST_DONE;
                end
            end
            rrnt_pkg::ST_SORT:
            begin
                if (sort_last)
                begin
                    state_next = rrnt_pkg::ST_DONE;
                end
            end
            rrnt_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = rrnt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrnt_pkg::ST_IDLE;
            end
        endcase
    end

    // State-machine outputs.
    always_comb
    begin
        s_tready        = 1'b0;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.tick  = 1'b0;
        xchg_ctrl.en    = 1'b0;
        xchg_ctrl.wr_en = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            rrnt_pkg::ST_IDLE:
            begin
                s_tready       = 1'b1;
                cell_ctrl.tick = s_tvalid && is_tick;
            end
            rrnt_pkg::ST_SORT:
            begin
                cell_ctrl.shift = 1'b1;
                xchg_ctrl.en    = 1'b1;
                xchg_ctrl.wr_en = write_reg && (pass_reg == '0);
            end
            rrnt_pkg::ST_DONE:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath and counter next values.
    always_comb
    begin
        pass_next     = pass_reg;
        step_next     = step_reg;
        write_next    = write_reg;
        widx_next     = widx_reg;
        new_next      = new_reg;
        outcome_next  = outcome_reg;
        evicted_next  = evicted_reg;
        lifetime_next = cfg_wr_en ? cfg_wr_data : lifetime_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (in_acc)
        begin
            if (is_tick)
            begin
                outcome_next = rrnt_pkg::OUT_AGED;
                evicted_next = evict_cnt[rrnt_pkg::CNT_W-1:0];
                write_next   = 1'b0;
            end
            else
            begin
                outcome_next  = rx_outcome;
                evicted_next  = '0;
                write_next    = rx_write;
                widx_next     = rx_idx;
                new_next.id   = in_id;
                new_next.rssi = in_rssi;
                new_next.life = lifetime_reg;
            end
        end

        if (cell_ctrl.shift)
        begin
            if (step_reg == LAST_IDX)
            begin
                step_next = '0;
                pass_next = sort_last ? '0 : pass_reg + PW'(1);
            end
            else
            begin
                step_next = step_reg + PW'(1);
            end
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = outcome_reg;
            m_tdata_next  = {2'b00, evicted_reg, live_cnt[rrnt_pkg::CNT_W-1:0],
                             slots[0].rssi, slots[0].id};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rrnt_pkg::ST_IDLE;
            pass_reg     <= '0;
            step_reg     <= '0;
            write_reg    <= 1'b0;
            lifetime_reg <= rrnt_pkg::LIFE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            step_reg     <= step_next;
            write_reg    <= write_next;
            lifetime_reg <= lifetime_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        widx_reg    <= widx_next;
        new_reg     <= new_next;
        outcome_reg <= outcome_next;
        evicted_reg <= evicted_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The ring must be aligned whenever a request can be looked up.
    a_aligned_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrnt_pkg::ST_IDLE) |-> (pass_reg == '0) && (step_reg == '0))
        else $error("ring not aligned in idle");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg <= LAST_IDX) && (pass_reg <= LAST_IDX))
        else $error("sort counter out of range");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrnt_pkg::ST_SORT) && (state_next == rrnt_pkg::ST_DONE)
        |=> ($signed(slots[0].rssi) >= $signed(slots[1].rssi)))
        else $error("head slot not strongest after sort");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == rrnt_pkg::ST_DONE))
        else $error("result produced outside final state");

endmodule

/* tb/tb_rssi_ranked_neighbor_table.sv */
// Self-checking testbench for rssi_ranked_neighbor_table: a directed table, then random traffic.
// Depends on rrnt_pkg and the RTL of the block; results are checked against a local predictor.
`timescale 1ns / 100ps

module tb_rssi_ranked_neighbor_table;

    localparam int DEPTH = 5;

    // Expected contents of one result transaction.
    typedef struct packed {
        rrnt_pkg::outcome_t                 outcome;
        logic [rrnt_pkg::ID_W-1:0]          best_id;
        logic signed [rrnt_pkg::RSSI_W-1:0] best_rssi;
        logic [rrnt_pkg::CNT_W-1:0]         live;
        logic [rrnt_pkg::CNT_W-1:0]         evicted;
    } status_t;

    typedef enum {ROW_RX, ROW_TICK, ROW_CFG} row_kind_t;

    // One row of the directed table. For a reload row the new value travels in id.
    typedef struct {
        row_kind_t                          kind;
        logic [rrnt_pkg::ID_W-1:0]          id;
        logic signed [rrnt_pkg::RSSI_W-1:0] rssi;
        bit                                 typed;
        status_t                            want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // [7:0] neighbor_id, [23:8] rssi
    logic [0:0]  s_tuser = '0;      // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;           // [7:0] best_id, [23:8] best_rssi, [26:24] live_count,
                                    // [29:27] evicted_count
    logic [2:0]  m_tuser;           // [2:0] outcome
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = '0;

    // Predictor state: a private copy of the neighbor slots and of the reload register.
    rrnt_pkg::slot_t             nbr_slots [DEPTH];
    logic [rrnt_pkg::LIFE_W-1:0] reload_copy;

    status_t   status_queue[$];
    plan_row_t plan_rows[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    rssi_ranked_neighbor_table #(
        .TABLE_DEPTH (DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 20 ns clock period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog. The slowest legal run needs well under a tenth of this.
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Every mismatch goes through here. Printing is capped so a badly broken block
    // cannot flood the log, but every mismatch is counted.
    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
    endtask

    function automatic status_t mk_status(input rrnt_pkg::outcome_t oc,
                                          input logic [rrnt_pkg::ID_W-1:0] bid,
                                          input logic signed [rrnt_pkg::RSSI_W-1:0] brssi,
                                          input int live, input int evicted);
        status_t st;
        st.outcome   = oc;
        st.best_id   = bid;
        st.best_rssi = brssi;
        st.live      = live[rrnt_pkg::CNT_W-1:0];
        st.evicted   = evicted[rrnt_pkg::CNT_W-1:0];
        return st;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [rrnt_pkg::ID_W-1:0] id,
                                    input logic signed [rrnt_pkg::RSSI_W-1:0] rssi,
                                    input bit typed, input status_t want);
        plan_row_t row;
        row.kind  = kind;
        row.id    = id;
        row.rssi  = rssi;
        row.typed = typed;
        row.want  = want;
        plan_rows.push_back(row);
    endfunction

    // Descending exchange sort over all slots, empty ones included. The pair order is
    // what fixes the placement of equal RSSI values, so it must not be changed.
    function automatic void rank_slots();
        rrnt_pkg::slot_t tmp;
        for (int i = 0; i < DEPTH - 1; i++)
            for (int j = i + 1; j < DEPTH; j++)
                if (nbr_slots[i].rssi < nbr_slots[j].rssi)
                begin
                    tmp          = nbr_slots[i];
                    nbr_slots[i] = nbr_slots[j];
                    nbr_slots[j] = tmp;
                end
    endfunction

    // Applies one request to the predictor's slots and returns the status the block
    // should report for it.
    function automatic status_t predict_status(input logic is_tick,
                                               input logic [rrnt_pkg::ID_W-1:0] id,
                                               input logic signed [rrnt_pkg::RSSI_W-1:0] rssi);
        status_t st;
        int      hit;
        int      gone;
        int      live;
        hit  = -1;
        gone = 0;
        live = 0;
        st.outcome = rrnt_pkg::OUT_DROPPED;
        if (is_tick)
        begin
            // Aging: count down, then clear every slot that has run out. No re-sort.
            st.outcome = rrnt_pkg::OUT_AGED;
            for (int k = 0; k < DEPTH; k++)
            begin
                if (nbr_slots[k].life != 0)
                    nbr_slots[k].life--;
                if (nbr_slots[k].life == 0)
                begin
                    if (nbr_slots[k].id != 0)
                        gone++;
                    nbr_slots[k].id   = '0;
                    nbr_slots[k].rssi = '0;
                end
            end
        end
        else if (id != 0)
        begin
            // An id of zero is never stored and leaves everything as it is.
            for (int k = 0; k < DEPTH; k++)
                if (hit < 0 && nbr_slots[k].id == id)
                    hit = k;
            if (hit >= 0)
                st.outcome = rrnt_pkg::OUT_UPDATED;
            else
            begin
                for (int k = 0; k < DEPTH; k++)
                    if (hit < 0 && nbr_slots[k].id == 0)
                        hit = k;
                if (hit >= 0)
                    st.outcome = rrnt_pkg::OUT_INSERTED;
                else if (rssi > nbr_slots[DEPTH-1].rssi)
                begin
                    hit        = DEPTH - 1;
                    st.outcome = rrnt_pkg::OUT_REPLACED;
                end
            end
            if (hit >= 0)
            begin
                nbr_slots[hit].id   = id;
                nbr_slots[hit].rssi = rssi;
                nbr_slots[hit].life = reload_copy;
                rank_slots();
            end
        end
        for (int k = 0; k < DEPTH; k++)
            if (nbr_slots[k].id != 0)
                live++;
        st.best_id   = nbr_slots[0].id;
        st.best_rssi = nbr_slots[0].rssi;
        st.live      = live[rrnt_pkg::CNT_W-1:0];
        st.evicted   = gone[rrnt_pkg::CNT_W-1:0];
        return st;
    endfunction

    // Drives one request transaction. Valid stays high after acceptance so that a
    // back-to-back request needs no second assignment in the same time step; any idle
    // cycles are inserted before the next request instead.
    task automatic send_item(input logic is_tick, input logic [rrnt_pkg::ID_W-1:0] id,
                             input logic signed [rrnt_pkg::RSSI_W-1:0] rssi, input bit typed,
                             input status_t want);
        status_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_tick;
        s_tdata  <= {rssi, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // The transaction was taken at this edge. The predictor runs even for rows
        // whose result is typed in, so that its slots stay in step with the block.
        predicted = predict_status(is_tick, id, rssi);
        status_queue.push_back(typed ? want : predicted);
    endtask

    // Stops sending and waits until every expected result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
    endtask

    // Writes the lifetime reload register; only called while the block is idle.
    task automatic write_reload(input logic [rrnt_pkg::LIFE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        reload_copy = value;
    endtask

    task automatic check_result();
        status_t want;
        results_seen++;
        if (status_queue.size() == 0)
        begin
            report_mismatch("result with nothing pending, outcome", m_tuser, -1);
            return;
        end
        want = status_queue.pop_front();
        if (m_tuser !== want.outcome)
            report_mismatch("outcome", m_tuser, want.outcome);
        if (m_tdata[7:0] !== want.best_id)
            report_mismatch("best_id", m_tdata[7:0], want.best_id);
        if (m_tdata[23:8] !== want.best_rssi)
            report_mismatch("best_rssi", $signed(m_tdata[23:8]), want.best_rssi);
        if (m_tdata[26:24] !== want.live)
            report_mismatch("live_count", m_tdata[26:24], want.live);
        if (m_tdata[29:27] !== want.evicted)
            report_mismatch("evicted_count", m_tdata[29:27], want.evicted);
    endtask

    // Result side: a result transaction completes at an edge where valid and ready
    // were both high. Ready is then redrawn for the next edge according to the
    // current stall rate.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result();
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Request side: reset, the directed table, then random phases.
    initial
    begin
        int          reload_plan [8];
        int          idle_plan   [4];
        int          stall_plan  [4];
        int          pick;
        int          small_val;
        logic        is_tick;
        logic [7:0]  id;
        logic [15:0] rssi;

        reload_plan = '{1, 15, 0, 5, 3, 15, 9, 1};
        idle_plan   = '{0, 84, 0, 31};
        stall_plan  = '{0, 0, 84, 31};
        reload_copy = rrnt_pkg::LIFE_RESET;
        for (int k = 0; k < DEPTH; k++)
            nbr_slots[k] = '0;

        // Directed table. The reload register keeps its reset value of five until
        // the first reload row.
        // Aging and a zero id on an empty table leave it empty.
        add_row(ROW_TICK, 8'd0, 16'sd0, 1'b1,
                mk_status(rrnt_pkg::OUT_AGED, 8'd0, 16'sd0, 0, 0));
        add_row(ROW_RX, 8'd0, 16'sd100, 1'b1,
                mk_status(rrnt_pkg::OUT_DROPPED, 8'd0, 16'sd0, 0, 0));
        // Largest id with the strongest RSSI, then a new id with the weakest.
        add_row(ROW_RX, 8'd255, 16'sd32767, 1'b1,
                mk_status(rrnt_pkg::OUT_INSERTED, 8'd255, 16'sd32767, 1, 0));
        add_row(ROW_RX, 8'd1, -16'sd32768, 1'b1,
                mk_status(rrnt_pkg::OUT_INSERTED, 8'd255, 16'sd32767, 2, 0));
        // Update of a known id, then fill the table, with an RSSI equal to that of
        // the empty slots among them.
        add_row(ROW_RX, 8'd1, 16'sd5, 1'b0, '0);
        add_row(ROW_RX, 8'd2, 16'sd0, 1'b0, '0);
        add_row(ROW_RX, 8'd3, -16'sd1, 1'b0, '0);
        add_row(ROW_RX, 8'd4, 16'sd100, 1'b0, '0);
        // Full table: a weaker and an equal RSSI are both dropped.
        add_row(ROW_RX, 8'd5, -16'sd32768, 1'b1,
                mk_status(rrnt_pkg::OUT_DROPPED, 8'd255, 16'sd32767, 5, 0));
        add_row(ROW_RX, 8'd6, -16'sd1, 1'b1,
                mk_status(rrnt_pkg::OUT_DROPPED, 8'd255, 16'sd32767, 5, 0));
        // A stronger one replaces the weakest.
        add_row(ROW_RX, 8'd7, 16'sd0, 1'b0, '0);
        add_row(ROW_RX, 8'd255, -16'sd32768, 1'b0, '0);
        add_row(ROW_RX, 8'd0, -16'sd32768, 1'b0, '0);
        add_row(ROW_RX, 8'hAA, 16'sh5555, 1'b0, '0);
        add_row(ROW_RX, 8'h55, 16'shAAAA, 1'b0, '0);
        // Five ticks age everything out; the fifth clears the whole table.
        for (int k = 0; k < 4; k++)
            add_row(ROW_TICK, 8'hFF, 16'shFFFF, 1'b0, '0);
        add_row(ROW_TICK, 8'h00, 16'sh0000, 1'b1,
                mk_status(rrnt_pkg::OUT_AGED, 8'd0, 16'sd0, 0, 5));
        add_row(ROW_TICK, 8'h5A, 16'sh3C3C, 1'b1,
                mk_status(rrnt_pkg::OUT_AGED, 8'd0, 16'sd0, 0, 0));
        // A negative RSSI sorts below the empty slots, so slot 0 stays empty.
        add_row(ROW_RX, 8'd9, -16'sd5, 1'b0, '0);
        // A reload of zero: the entry is stored and then cleared by the next tick.
        add_row(ROW_CFG, 8'd0, 16'sd0, 1'b0, '0);
        add_row(ROW_RX, 8'd10, 16'sd7, 1'b0, '0);
        add_row(ROW_TICK, 8'd0, 16'sd0, 1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 31;
        recv_stall_pct = 31;
        foreach (plan_rows[r])
        begin
            if (plan_rows[r].kind == ROW_CFG)
            begin
                wait_drained();
                write_reload(plan_rows[r].id[rrnt_pkg::LIFE_W-1:0]);
            end
            else
                send_item(plan_rows[r].kind == ROW_TICK, plan_rows[r].id, plan_rows[r].rssi,
                          plan_rows[r].typed, plan_rows[r].want);
        end

        // Random phases. Each one starts from an idle block, so the sender pauses
        // until every result has come before the reload is rewritten.
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_drained();
            if (phase == 6)
                write_reload(4'($urandom_range(0, 15)));
            else
                write_reload(4'(reload_plan[phase]));
            send_idle_pct  = idle_plan[phase % 4];
            recv_stall_pct = stall_plan[phase % 4];
            for (int n = 0; n < 175; n++)
            begin
                is_tick = ($urandom_range(0, 5) == 0);
                // A small pool of ids keeps the table full and exercises updates and
                // replacement; the rest covers every id bit, zero included.
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    id = 8'($urandom_range(1, 7));
                else if (pick < 90)
                    id = 8'($urandom_range(1, 255));
                else if (pick < 95)
                    id = 8'd0;
                else
                    id = 8'd255;
                // Small values give many ties with each other and with empty slots.
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    small_val = int'($urandom_range(0, 6)) - 3;
                    rssi      = small_val[15:0];
                end
                else if (pick < 45)
                begin
                    case ($urandom_range(0, 3))
                        0:       rssi = 16'h7FFF;
                        1:       rssi = 16'h8000;
                        2:       rssi = 16'h7FFE;
                        default: rssi = 16'h8001;
                    endcase
                end
                else
                    rssi = 16'($urandom);
                send_item(is_tick, id, rssi, 1'b0, '0);
            end
        end

        // Let everything drain, then watch for stray results a little longer than
        // the slowest request takes.
        wait_drained();
        repeat (DEPTH * DEPTH + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
